FILE: rtl/crlf_pkg.sv
// Shared types and constants for the CR/LF line receiver with echo.
// Holds the command word passed from front to back, the back-end state type
// and the response prefix table. Depends on nothing.
package crlf_pkg;

	// Count and index width, which covers any supported line capacity.
	localparam int CNT_W = 6;

	// Character codes.
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Length of the "response text:" prefix; the space follows at this position.
	localparam logic [CNT_W-1:0] PREFIX_LEN = 6'd14;

	// Command kinds carried through the queue.
	typedef enum logic {
		OP_STORE,
		OP_EMIT
	} op_t;

	// One queue entry: store a byte at an index, or emit a line of a given length.
	typedef struct packed {
		op_t              op;
		logic [7:0]       data;
		logic [CNT_W-1:0] idx;
	} cmd_t;

	// Back-end sequencer states.
	typedef enum logic {
		BK_IDLE,
		BK_EMIT
	} back_state_t;

	// Characters of the response prefix, by position.
	function automatic logic [7:0] prefix_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0: c = 8'h72;    // r
			4'd1: c = 8'h65;    // e
			4'd2: c = 8'h73;    // s
			4'd3: c = 8'h70;    // p
			4'd4: c = 8'h6F;    // o
			4'd5: c = 8'h6E;    // n
			4'd6: c = 8'h73;    // s
			4'd7: c = 8'h65;    // e
			4'd8: c = 8'h20;    // space
			4'd9: c = 8'h74;    // t
			4'd10: c = 8'h65;   // e
			4'd11: c = 8'h78;   // x
			4'd12: c = 8'h74;   // t
			4'd13: c = 8'h3A;   // colon
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/crlf_front.sv
// Front end of the line receiver: accepts received words and classifies them.
// Tracks the CR flag and the line count, and pushes store and emit commands.
// Depends on crlf_pkg.
module crlf_front #(
	parameter int LINE_CAPACITY = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       rx_byte,
	output logic             push,
	output crlf_pkg::cmd_t   push_cmd,
	input  logic             q_full
);
	import crlf_pkg::*;

	localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);

	logic             cr_q;
	logic [CNT_W-1:0] len_q;
	logic             accept;
	logic             cr_d;
	logic [CNT_W-1:0] len_d;

	// A word is taken whenever the queue has room for a possible command.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Classify the incoming word against the CR flag and the line count.
	always_comb begin
		push     = 1'b0;
		push_cmd = '{op: OP_STORE, data: rx_byte, idx: len_q};
		cr_d     = cr_q;
		len_d    = len_q;
		if (accept) begin
			if (cr_q) begin
				// LF completes the line; anything else discards it.
				if (rx_byte == CHAR_LF) begin
					push        = 1'b1;
					push_cmd.op = OP_EMIT;
				end
				cr_d  = 1'b0;
				len_d = '0;
			end else if (rx_byte == CHAR_CR) begin
				cr_d = 1'b1;
			end else if (len_q < CAP) begin
				push  = 1'b1;
				len_d = len_q + 1'b1;
			end else begin
				// The store is full, so the line is dropped.
				len_d = '0;
			end
		end
	end

	// Line state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_q  <= 1'b0;
			len_q <= '0;
		end else begin
			cr_q  <= cr_d;
			len_q <= len_d;
		end
	end

endmodule

FILE: rtl/crlf_fifo.sv
// Short command queue between the front and back ends of the line receiver.
// A circular buffer of command words with a fill count.
// Depends on crlf_pkg.
module crlf_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  crlf_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output crlf_pkg::cmd_t head
);
	import crlf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          buf_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = buf_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	// The front end must never push into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("command pushed into a full queue");
	// The back end must never pop an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> valid)
		else $error("command popped from an empty queue");
`endif

endmodule

FILE: rtl/crlf_back.sv
// Back end of the line receiver: executes store and emit commands.
// Owns the line memory, the response sequencer and the output register.
// Depends on crlf_pkg.
module crlf_back #(
	parameter int LINE_CAPACITY = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  crlf_pkg::cmd_t q_head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     tx_byte,
	output logic           last_of_run
);
	import crlf_pkg::*;

	localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

	logic [7:0]       line_mem [LINE_CAPACITY];
	back_state_t      state_q;
	back_state_t      state_d;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] pos_d;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] body_idx;
	logic [7:0]       rd_data_q;
	logic             out_valid_q;
	logic [7:0]       tx_q;
	logic             last_q;
	logic             load;
	logic             last_pos;
	logic [7:0]       byte_sel;

	assign out_valid   = out_valid_q;
	assign tx_byte     = tx_q;
	assign last_of_run = last_q;

	// Position of the final word of the run and the word at the current position.
	assign last_pos = (pos_q == PREFIX_LEN + len_q);
	always_comb begin
		if (pos_q < PREFIX_LEN) begin
			byte_sel = prefix_char(pos_q[3:0]);
		end else if (pos_q == PREFIX_LEN) begin
			byte_sel = CHAR_SPACE;
		end else begin
			byte_sel = rd_data_q;
		end
	end

	// Sequencer outputs: pop a command when idle, load a word when the register frees.
	always_comb begin
		pop  = 1'b0;
		load = 1'b0;
		case (state_q)
			BK_IDLE: pop  = q_valid;
			BK_EMIT: load = !out_valid_q || out_ready;
			default: begin
				pop  = 1'b0;
				load = 1'b0;
			end
		endcase
	end

	// Sequencer next state and next position.
	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		case (state_q)
			BK_IDLE: begin
				pos_d = '0;
				if (pop && q_head.op == OP_EMIT) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (load) begin
					if (last_pos) begin
						state_d = BK_IDLE;
						pos_d   = '0;
					end else begin
						pos_d = pos_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
				pos_d   = '0;
			end
		endcase
	end

	// Line memory: written by store commands, read one word ahead of the output.
	assign body_idx = pos_d - (PREFIX_LEN + 1'b1);
	always_ff @(posedge clk) begin
		if (pop && q_head.op == OP_STORE) begin
			line_mem[q_head.idx[AW-1:0]] <= q_head.data;
		end
		if (pos_d > PREFIX_LEN) begin
			rd_data_q <= line_mem[body_idx[AW-1:0]];
		end
	end

	// Line length latched at the start of a run.
	always_ff @(posedge clk) begin
		if (pop && q_head.op == OP_EMIT) begin
			len_q <= q_head.idx;
		end
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (load) begin
			tx_q   <= byte_sel;
			last_q <= last_pos;
		end
	end

`ifndef SYNTHESIS
	// A run never steps past its final word.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_EMIT |-> pos_q <= PREFIX_LEN + len_q)
		else $error("response position beyond end of run");
	// Every run starts at the first prefix character.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == BK_EMIT) |-> pos_q == '0)
		else $error("response run started mid-sequence");
	// Store commands always address an entry inside the line memory.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_head.op == OP_STORE) |-> q_head.idx < CNT_W'(LINE_CAPACITY))
		else $error("store command beyond line capacity");
`endif

endmodule

FILE: rtl/crlf_line_receiver_with_echo.sv
// Top level of the CR/LF line receiver with echo.
// Connects the front end, the command queue and the back end.
// Depends on crlf_pkg, crlf_front, crlf_fifo and crlf_back.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------
//   input   | in_valid / in_ready  | rx_byte
//   output  | out_valid / out_ready| tx_byte, last_of_run
//
// The front end takes one word per cycle while the command queue has room.
// A line word passes through the command queue to the line memory when the
// idle back end pops it; a completed line gives 15 + length output words,
// one per cycle while out_ready is high, set by the single output register.
// The front keeps accepting during a run until QUEUE_DEPTH commands wait.
// Reset is asynchronous and clears control state only; there is no clearing pass.
module crlf_line_receiver_with_echo #(
	parameter int LINE_CAPACITY = 32,
	parameter int QUEUE_DEPTH   = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] tx_byte,
	output logic       last_of_run
);
	import crlf_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic pop;
	logic q_valid;
	cmd_t q_head;

	// Classification of received words.
	crlf_front #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	// Command queue.
	crlf_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	// Line storage and response generation.
	crlf_back #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.tx_byte     (tx_byte),
		.last_of_run (last_of_run)
	);

endmodule

FILE: dv/crlf_line_receiver_with_echo_test.sv
// Self-checking testbench for the CR/LF line receiver with echo.
// Drives received bytes, predicts each echoed response word and checks it in order.
// Depends on crlf_pkg and crlf_line_receiver_with_echo.
module crlf_line_receiver_with_echo_test;

	import crlf_pkg::CHAR_CR;
	import crlf_pkg::CHAR_LF;
	import crlf_pkg::CHAR_SPACE;

	localparam int LINE_CAP = 32;
	localparam int RANDOM_BYTES = 230;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PREFIX_CHARS = 14;
	localparam logic [8*PREFIX_CHARS-1:0] RESP_PREFIX = "response text:";

	// How a generated line is closed.
	typedef enum int {
		END_CRLF,
		END_CR_OTHER,
		END_OPEN
	} line_end_t;

	// One response word as seen on the output channel.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} tx_word_t;

	// Tracks the line state, predicts response words and checks them.
	class line_echo_scoreboard;
		tx_word_t   expected_tx[$];
		logic [5:0] line_len;
		logic       cr_pending;
		logic [7:0] line_bytes [LINE_CAP];
		int         mismatches;
		int         words_checked;
		int         lines_echoed;
		int         lines_dropped;

		function new();
			line_len = '0;
			cr_pending = 1'b0;
			mismatches = 0;
			words_checked = 0;
			lines_echoed = 0;
			lines_dropped = 0;
		endfunction

		function int pending();
			return expected_tx.size();
		endfunction

		function int failures();
			return mismatches + expected_tx.size();
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%s", msg);
			end
		endfunction

		// Updates the line state for one accepted byte and queues any response.
		function void note_rx_byte(logic [7:0] b);
			int i;
			if (cr_pending) begin
				if (b != CHAR_LF) begin
					lines_dropped++;
				end else begin
					for (i = 0; i < PREFIX_CHARS; i++) begin
						expected_tx.push_back({RESP_PREFIX[8*(PREFIX_CHARS-1-i) +: 8], 1'b0});
					end
					expected_tx.push_back({CHAR_SPACE, line_len == 0});
					for (i = 0; i < int'(line_len); i++) begin
						expected_tx.push_back({line_bytes[i], i + 1 == int'(line_len)});
					end
					lines_echoed++;
				end
				line_len = '0;
				cr_pending = 1'b0;
			end else if (b == CHAR_CR) begin
				cr_pending = 1'b1;
			end else if (int'(line_len) < LINE_CAP) begin
				line_bytes[line_len] = b;
				line_len = line_len + 6'd1;
			end else begin
				// A byte into a full store throws the line away.
				lines_dropped++;
				line_len = '0;
			end
		endfunction

		// Compares one accepted output word with the oldest expected word.
		function void check_tx_byte(logic [7:0] data, logic last);
			tx_word_t want;
			if (expected_tx.size() == 0) begin
				flag($sformatf("unexpected word: tx_byte=%02h last_of_run=%0b", data, last));
			end else begin
				want = expected_tx.pop_front();
				words_checked++;
				if (data !== want.data || last !== want.last) begin
					flag($sformatf("word %0d: expected tx_byte=%02h last_of_run=%0b, got %02h %0b",
						words_checked, want.data, want.last, data, last));
				end
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] tx_byte;
	logic       last_of_run;

	line_echo_scoreboard echo_sb;
	int send_idle_pct = 38;
	int recv_stall_pct = 63;
	int bytes_sent = 0;
	int cycle_count = 0;

	crlf_line_receiver_with_echo #(
		.LINE_CAPACITY(LINE_CAP)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.tx_byte    (tx_byte),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watches both channels; inputs are noted before outputs are checked.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			echo_sb.note_rx_byte(rx_byte);
		end
		if (arst_n && out_valid && out_ready) begin
			echo_sb.check_tx_byte(tx_byte, last_of_run);
		end
	end

	// The receiver stalls at random at the current rate.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Ends a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles.", cycle_count);
			$display("FAIL");
			$finish;
		end
	end

	// Presents one word and holds it until accepted; valid stays high afterward.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do begin
			@(posedge clk);
		end while (!in_ready);
		bytes_sent++;
	endtask

	// Lowers valid and waits until every predicted word has been received.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (echo_sb.pending() != 0);
	endtask

	// Sends a line of random content, then closes it as asked.
	task automatic send_line(input int len, input line_end_t close);
		int i;
		logic [7:0] b;
		for (i = 0; i < len; i++) begin
			b = ($urandom_range(0, 15) == 0) ? CHAR_LF : 8'($urandom_range(0, 255));
			send_byte(b);
		end
		case (close)
			END_CRLF: begin
				send_byte(CHAR_CR);
				send_byte(CHAR_LF);
			end
			END_CR_OTHER: begin
				send_byte(CHAR_CR);
				send_byte(($urandom_range(0, 3) == 0) ? CHAR_CR : 8'($urandom_range(0, 255)));
			end
			default: begin
			end
		endcase
	endtask

	initial begin
		int start_count;
		int len;
		int pick;
		int phase;
		int cur_phase;
		int line_no;
		line_end_t close;

		echo_sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty line, byte extremes, a bare LF as data,
		// a stray byte after CR, and a second CR.
		send_byte(CHAR_CR);
		send_byte(CHAR_LF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CHAR_CR);
		send_byte(CHAR_LF);
		send_byte(CHAR_LF);
		send_byte(8'h61);
		send_byte(CHAR_CR);
		send_byte(CHAR_LF);
		send_byte(8'h78);
		send_byte(CHAR_CR);
		send_byte(8'h79);
		send_byte(CHAR_CR);
		send_byte(CHAR_LF);
		send_byte(8'h7A);
		send_byte(CHAR_CR);
		send_byte(CHAR_CR);
		send_byte(8'h55);
		send_byte(CHAR_CR);
		send_byte(CHAR_LF);

		// Random part in three idle phases; the sender drains at each change.
		start_count = bytes_sent;
		cur_phase = 0;
		line_no = 0;
		while (bytes_sent - start_count < RANDOM_BYTES) begin
			phase = (bytes_sent - start_count) * 3 / RANDOM_BYTES;
			if (phase != cur_phase) begin
				wait_for_drain();
				cur_phase = phase;
				send_idle_pct = (phase == 1) ? 63 : 0;
				recv_stall_pct = (phase == 1) ? 38 : 0;
			end
			pick = $urandom_range(0, 99);
			close = (pick < 80) ? END_CRLF : (pick < 92) ? END_CR_OTHER : END_OPEN;
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = $urandom_range(0, 6);
			end else if (pick < 92) begin
				len = $urandom_range(7, 20);
			end else begin
				len = $urandom_range(LINE_CAP - 3, LINE_CAP + 2);
			end
			// A full line first, then one that overflows the store.
			if (line_no == 0) begin
				len = LINE_CAP;
				close = END_CRLF;
			end else if (line_no == 1) begin
				len = LINE_CAP + 1;
				close = END_CRLF;
			end
			send_line(len, close);
			line_no++;
		end

		// Finish: drain, then let the block settle before the verdict.
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d bytes in %0d random lines; %0d lines echoed, %0d dropped.",
			bytes_sent, line_no, echo_sb.lines_echoed, echo_sb.lines_dropped);
		$display("Checked %0d response words; %0d mismatches, %0d words never arrived.",
			echo_sb.words_checked, echo_sb.mismatches, echo_sb.pending());
		if (echo_sb.failures() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/crlf_pkg.sv
rtl/crlf_front.sv
rtl/crlf_fifo.sv
rtl/crlf_back.sv
rtl/crlf_line_receiver_with_echo.sv
dv/crlf_line_receiver_with_echo_test.sv
